// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge.
`define MVNA_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, off while reset is high.
`define MVNA_ASSERT_DIS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== design/mvna_pkg.sv =====
package mvna_pkg;

  localparam int IDX_W        = 12;
  localparam int CNT_W        = 13;
  localparam logic [CNT_W-1:0] MAX_VERTICES = 13'd4096;
  localparam int NRM_W        = 48;
  localparam int ACC_W        = 64;
  localparam int WGT_W        = 48;
  localparam int ALU_W        = 96;
  localparam int DIV_W        = 80;
  localparam int STEP_W       = 7;
  localparam logic [STEP_W-1:0] MUL_LAST  = 7'd3;
  localparam logic [STEP_W-1:0] DIV_LAST  = 7'd79;
  localparam logic [STEP_W-1:0] SQRT_LAST = 7'd47;

  localparam logic [0:0] REG_NORMALIZE = 1'd0;
  localparam logic [0:0] REG_MODE      = 1'd1;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_CROSS,
    S_SQ,
    S_SQW,
    S_SQRT,
    S_SQRTW,
    S_DECIDE,
    S_DIV,
    S_DIVW,
    S_WGT,
    S_WGTW,
    S_ACRD,
    S_ACWR,
    S_QRD,
    S_QCHK,
    S_AVG,
    S_AVGW,
    S_EMIT
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [11:0]        corner_a;
    logic [11:0]        corner_b;
    logic [11:0]        corner_c;
  } item_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    status_t                 result_status;
    logic [15:0]             item_index;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
    logic [WGT_W-1:0]        w;
  } acc_entry_t;

endpackage

// ===== design/mvna_alu.sv =====
module mvna_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  mvna_pkg::alu_req_t          req,
  input  logic [mvna_pkg::ALU_W-1:0]  opa,
  input  logic [mvna_pkg::WGT_W-1:0]  opb,
  output logic                        done,
  output logic [mvna_pkg::ALU_W-1:0]  res
);

  mvna_pkg::alu_op_t               op_r;
  logic                            busy;
  logic [mvna_pkg::STEP_W-1:0]     step;
  logic [mvna_pkg::ALU_W-1:0]      x;
  logic [49:0]                     rem;
  logic [47:0]                     root;
  logic [47:0]                     a_r;
  logic [47:0]                     b_r;

  logic [23:0]  pa;
  logic [23:0]  pb;
  logic [47:0]  pp;
  logic [95:0]  pp_sh;
  logic [48:0]  drem;
  logic         dge;
  logic [51:0]  srem;
  logic [51:0]  trial;
  logic         sge;
  logic         last;

  always_comb begin
    pa = step[1] ? a_r[47:24] : a_r[23:0];
    pb = step[0] ? b_r[47:24] : b_r[23:0];
    pp = pa * pb;
    case (step[1:0])
      2'd0:    pp_sh = {48'b0, pp};
      2'd3:    pp_sh = {pp, 48'b0};
      default: pp_sh = {24'b0, pp, 24'b0};
    endcase
    drem  = {rem[47:0], x[mvna_pkg::DIV_W-1]};
    dge   = drem >= {1'b0, b_r};
    srem  = {rem, x[95:94]};
    trial = {2'b0, root, 2'b01};
    sge   = srem >= trial;
    unique case (op_r)
      mvna_pkg::ALU_MUL: last = step == mvna_pkg::MUL_LAST;
      mvna_pkg::ALU_DIV: last = step == mvna_pkg::DIV_LAST;
      default:           last = step == mvna_pkg::SQRT_LAST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      step <= '0;
      x    <= (req.op == mvna_pkg::ALU_MUL) ? '0 : opa;
      rem  <= '0;
      root <= '0;
      a_r  <= opa[47:0];
      b_r  <= opb;
    end else if (busy) begin
      step <= step + 1'b1;
      unique case (op_r)
        mvna_pkg::ALU_MUL: begin
          x <= x + pp_sh;
        end
        mvna_pkg::ALU_DIV: begin
          rem <= {2'b0, dge ? (drem[47:0] - b_r) : drem[47:0]};
          x[mvna_pkg::DIV_W-1:0] <= {x[mvna_pkg::DIV_W-2:0], dge};
        end
        default: begin
          rem  <= sge ? (srem[49:0] - trial[49:0]) : srem[49:0];
          root <= {root[46:0], sge};
          x    <= {x[93:0], 2'b00};
        end
      endcase
    end
  end

  always_comb begin
    unique case (op_r)
      mvna_pkg::ALU_MUL: res = x;
      mvna_pkg::ALU_DIV: res = {16'b0, x[mvna_pkg::DIV_W-1:0]};
      default:           res = {48'b0, root};
    endcase
  end

endmodule

// ===== design/mesh_vertex_normal_accumulator_top.sv =====
// Area-weighted vertex normals for a triangle mesh. A load or a clear is handled when it is
// accepted. A triangle reads its three corners from the position memory and forms the cross
// product; one shared multi-cycle unit then does everything wide: the multiplies, the square
// root and the divided components, where the divider is bit-serial. A smooth triangle
// includes three read-modify-write passes over the accumulator memory; a flat triangle
// divides only when normalized. A query divides by the accumulated weight, and is normalized
// as well when normalizing is on. The accumulator entry of a vertex is zeroed when the
// vertex is loaded, so neither reset nor a clear needs a pass over the memories.
module mesh_vertex_normal_accumulator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mvna_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output mvna_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [0:0]          cfg_data
);

  localparam logic signed [63:0] AMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  mvna_pkg::state_t      state;
  mvna_pkg::state_t      state_next;
  mvna_pkg::item_t       cur;
  mvna_pkg::status_t     st;
  mvna_pkg::alu_req_t    alu_req;
  mvna_pkg::pos_t        pos_mem [1 << mvna_pkg::IDX_W];
  mvna_pkg::acc_entry_t  acc_mem [1 << mvna_pkg::IDX_W];
  mvna_pkg::pos_t        pos_q;
  mvna_pkg::acc_entry_t  acc_q;
  mvna_pkg::pos_t        p [3];
  mvna_pkg::acc_entry_t  acc_wdata;

  logic                              norm;
  logic                              mode;
  logic [mvna_pkg::CNT_W-1:0]        vcount;
  logic [15:0]                       fcount;
  logic [15:0]                       item_idx;
  logic                              zero_out;
  logic [1:0]                        k;
  logic [2:0]                        cstep;
  logic signed [mvna_pkg::NRM_W-1:0] v [3];
  logic signed [mvna_pkg::ACC_W-1:0] wn [3];
  logic signed [mvna_pkg::ACC_W-1:0] ac [3];
  logic [mvna_pkg::WGT_W-1:0]        wsum;
  logic [mvna_pkg::WGT_W-1:0]        w;
  logic [mvna_pkg::ALU_W-1:0]        ssum;
  logic signed [33:0]                tmp;

  logic                              accept;
  logic                              bad_tri;
  logic                              bad_q;
  logic                              load_we;
  logic                              acc_we;
  logic [mvna_pkg::IDX_W-1:0]        pos_raddr;
  logic [mvna_pkg::IDX_W-1:0]        acc_raddr;
  logic [mvna_pkg::IDX_W-1:0]        acc_waddr;
  logic [mvna_pkg::IDX_W-1:0]        corner_k;
  logic [mvna_pkg::ALU_W-1:0]        opa;
  logic [mvna_pkg::WGT_W-1:0]        opb;
  logic                              alu_done;
  logic [mvna_pkg::ALU_W-1:0]        alu_res;
  logic [1:0]                        k_inc;
  logic                              k_last;
  logic [mvna_pkg::NRM_W-1:0]        vmag;
  logic [mvna_pkg::ACC_W-1:0]        amag;
  logic signed [16:0]                ux, uy, uz, vx, vy, vz;
  logic signed [16:0]                m1, m2;
  logic signed [33:0]                prod;
  logic signed [34:0]                cdiff;
  logic [mvna_pkg::NRM_W-1:0]        qn;
  logic                              qover;
  logic signed [64:0]                sx, sy, sz;
  logic [48:0]                       wnew;

  function automatic logic signed [63:0] sat_acc(input logic signed [64:0] s);
    if (s > 65'(AMAX)) begin
      sat_acc = AMAX;
    end else if (s < -65'(AMAX)) begin
      sat_acc = -AMAX;
    end else begin
      sat_acc = s[63:0];
    end
  endfunction

  mvna_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .opa  (opa),
    .opb  (opb),
    .done (alu_done),
    .res  (alu_res)
  );

  assign item_stall = state != mvna_pkg::S_IDLE;
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign bad_q      = {1'b0, item.corner_a} >= vcount;
  assign bad_tri    = bad_q || ({1'b0, item.corner_b} >= vcount) ||
                      ({1'b0, item.corner_c} >= vcount);
  assign k_last     = k == 2'd2;
  assign k_inc      = k_last ? 2'd0 : k + 2'd1;
  assign vmag       = v[k][mvna_pkg::NRM_W-1] ? -v[k] : v[k];
  assign amag       = ac[k][mvna_pkg::ACC_W-1] ? -ac[k] : ac[k];
  assign qn         = alu_res[mvna_pkg::NRM_W-1:0];
  assign qover      = |alu_res[mvna_pkg::DIV_W-1:mvna_pkg::NRM_W-1];

  always_comb begin
    case (k)
      2'd0:    corner_k = cur.corner_a;
      2'd1:    corner_k = cur.corner_b;
      default: corner_k = cur.corner_c;
    endcase
  end

  always_comb begin
    ux = 17'(p[1].x) - 17'(p[0].x);
    uy = 17'(p[1].y) - 17'(p[0].y);
    uz = 17'(p[1].z) - 17'(p[0].z);
    vx = 17'(p[2].x) - 17'(p[0].x);
    vy = 17'(p[2].y) - 17'(p[0].y);
    vz = 17'(p[2].z) - 17'(p[0].z);
    case (cstep)
      3'd0:    begin m1 = uy; m2 = vz; end
      3'd1:    begin m1 = uz; m2 = vy; end
      3'd2:    begin m1 = uz; m2 = vx; end
      3'd3:    begin m1 = ux; m2 = vz; end
      3'd4:    begin m1 = ux; m2 = vy; end
      3'd5:    begin m1 = uy; m2 = vx; end
      default: begin m1 = '0; m2 = '0; end
    endcase
    prod  = m1 * m2;
    cdiff = 35'(tmp) - 35'(prod);
  end

  always_comb begin
    sx   = 65'(acc_q.x) + 65'(wn[0]);
    sy   = 65'(acc_q.y) + 65'(wn[1]);
    sz   = 65'(acc_q.z) + 65'(wn[2]);
    wnew = {1'b0, acc_q.w} + {1'b0, w};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mvna_pkg::S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            mvna_pkg::KIND_TRI: begin
              if (bad_tri) begin
                state_next = mode ? mvna_pkg::S_IDLE : mvna_pkg::S_EMIT;
              end else begin
                state_next = mvna_pkg::S_RD0;
              end
            end
            mvna_pkg::KIND_QUERY: begin
              state_next = bad_q ? mvna_pkg::S_EMIT : mvna_pkg::S_QRD;
            end
            default: state_next = mvna_pkg::S_IDLE;
          endcase
        end
      end
      mvna_pkg::S_RD0: state_next = mvna_pkg::S_RD1;
      mvna_pkg::S_RD1: state_next = mvna_pkg::S_RD2;
      mvna_pkg::S_RD2: state_next = mvna_pkg::S_RD3;
      mvna_pkg::S_RD3: state_next = mvna_pkg::S_CROSS;
      mvna_pkg::S_CROSS: begin
        if (cstep == 3'd5) begin
          state_next = mvna_pkg::S_SQ;
        end
      end
      mvna_pkg::S_SQ: state_next = mvna_pkg::S_SQW;
      mvna_pkg::S_SQW: begin
        if (alu_done) begin
          state_next = k_last ? mvna_pkg::S_SQRT : mvna_pkg::S_SQ;
        end
      end
      mvna_pkg::S_SQRT: state_next = mvna_pkg::S_SQRTW;
      mvna_pkg::S_SQRTW: begin
        if (alu_done) begin
          state_next = mvna_pkg::S_DECIDE;
        end
      end
      mvna_pkg::S_DECIDE: begin
        if (cur.kind == mvna_pkg::KIND_TRI && mode) begin
          state_next = mvna_pkg::S_WGT;
        end else if (w == '0) begin
          state_next = mvna_pkg::S_EMIT;
        end else if (cur.kind == mvna_pkg::KIND_TRI && !norm) begin
          state_next = mvna_pkg::S_EMIT;
        end else begin
          state_next = mvna_pkg::S_DIV;
        end
      end
      mvna_pkg::S_DIV: state_next = mvna_pkg::S_DIVW;
      mvna_pkg::S_DIVW: begin
        if (alu_done) begin
          state_next = k_last ? mvna_pkg::S_EMIT : mvna_pkg::S_DIV;
        end
      end
      mvna_pkg::S_WGT: state_next = mvna_pkg::S_WGTW;
      mvna_pkg::S_WGTW: begin
        if (alu_done) begin
          state_next = k_last ? mvna_pkg::S_ACRD : mvna_pkg::S_WGT;
        end
      end
      mvna_pkg::S_ACRD: state_next = mvna_pkg::S_ACWR;
      mvna_pkg::S_ACWR: state_next = k_last ? mvna_pkg::S_IDLE : mvna_pkg::S_ACRD;
      mvna_pkg::S_QRD: state_next = mvna_pkg::S_QCHK;
      mvna_pkg::S_QCHK: begin
        state_next = (acc_q.w == '0) ? mvna_pkg::S_EMIT : mvna_pkg::S_AVG;
      end
      mvna_pkg::S_AVG: state_next = mvna_pkg::S_AVGW;
      mvna_pkg::S_AVGW: begin
        if (alu_done && k_last) begin
          state_next = norm ? mvna_pkg::S_SQ : mvna_pkg::S_EMIT;
        end else if (alu_done) begin
          state_next = mvna_pkg::S_AVG;
        end
      end
      mvna_pkg::S_EMIT: begin
        if (!result_valid || !result_stall) begin
          state_next = mvna_pkg::S_IDLE;
        end
      end
      default: state_next = mvna_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = mvna_pkg::ALU_MUL;
    opa           = {48'b0, vmag};
    opb           = vmag;
    pos_raddr     = cur.corner_a;
    acc_raddr     = corner_k;
    load_we       = accept && item.kind == mvna_pkg::KIND_LOAD &&
                    vcount < mvna_pkg::MAX_VERTICES;
    acc_we        = load_we;
    acc_waddr     = vcount[mvna_pkg::IDX_W-1:0];
    acc_wdata     = '0;
    unique case (state)
      mvna_pkg::S_RD1: pos_raddr = cur.corner_b;
      mvna_pkg::S_RD2: pos_raddr = cur.corner_c;
      mvna_pkg::S_SQ: begin
        alu_req.start = 1'b1;
      end
      mvna_pkg::S_SQRT: begin
        alu_req.start = 1'b1;
        alu_req.op    = mvna_pkg::ALU_SQRT;
        opa           = ssum;
      end
      mvna_pkg::S_DIV: begin
        alu_req.start = 1'b1;
        alu_req.op    = mvna_pkg::ALU_DIV;
        opa           = {32'b0, vmag, 16'b0};
        opb           = w;
      end
      mvna_pkg::S_WGT: begin
        alu_req.start = 1'b1;
        opb           = w;
      end
      mvna_pkg::S_AVG: begin
        alu_req.start = 1'b1;
        alu_req.op    = mvna_pkg::ALU_DIV;
        opa           = {16'b0, amag, 16'b0};
        opb           = wsum;
      end
      mvna_pkg::S_ACWR: begin
        acc_we      = 1'b1;
        acc_waddr   = corner_k;
        acc_wdata.x = sat_acc(sx);
        acc_wdata.y = sat_acc(sy);
        acc_wdata.z = sat_acc(sz);
        acc_wdata.w = wnew[48] ? '1 : wnew[47:0];
      end
      mvna_pkg::S_QRD: acc_raddr = cur.corner_a;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      pos_mem[vcount[mvna_pkg::IDX_W-1:0]] <= '{x: item.coord_x, y: item.coord_y,
                                                 z: item.coord_z};
    end
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    pos_q <= pos_mem[pos_raddr];
    acc_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mvna_pkg::S_IDLE;
      norm   <= 1'b1;
      mode   <= 1'b1;
      vcount <= '0;
      fcount <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mvna_pkg::REG_NORMALIZE: norm <= cfg_data[0];
          mvna_pkg::REG_MODE:      mode <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (load_we) begin
        vcount <= vcount + 1'b1;
      end
      if (accept && item.kind == mvna_pkg::KIND_CLEAR) begin
        vcount <= '0;
        fcount <= '0;
      end
      if (accept && item.kind == mvna_pkg::KIND_TRI) begin
        fcount <= fcount + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mvna_pkg::S_IDLE: begin
        cur      <= item;
        k        <= '0;
        cstep    <= '0;
        ssum     <= '0;
        st       <= mvna_pkg::ST_OK;
        zero_out <= 1'b0;
        if (item.kind == mvna_pkg::KIND_TRI) begin
          item_idx <= fcount;
          if (bad_tri) begin
            st       <= mvna_pkg::ST_BAD;
            zero_out <= 1'b1;
          end
        end else begin
          item_idx <= {{(16 - mvna_pkg::IDX_W){1'b0}}, item.corner_a};
          if (bad_q) begin
            st       <= mvna_pkg::ST_BAD;
            zero_out <= 1'b1;
          end
        end
      end
      mvna_pkg::S_RD1: p[0] <= pos_q;
      mvna_pkg::S_RD2: p[1] <= pos_q;
      mvna_pkg::S_RD3: p[2] <= pos_q;
      mvna_pkg::S_CROSS: begin
        cstep <= cstep + 1'b1;
        if (!cstep[0]) begin
          tmp <= prod;
        end else begin
          v[cstep[2:1]] <= {{(mvna_pkg::NRM_W - 35){cdiff[34]}}, cdiff};
        end
      end
      mvna_pkg::S_SQW: begin
        if (alu_done) begin
          ssum <= ssum + alu_res;
          k    <= k_inc;
        end
      end
      mvna_pkg::S_SQRTW: begin
        if (alu_done) begin
          w <= alu_res[mvna_pkg::WGT_W-1:0];
        end
      end
      mvna_pkg::S_DECIDE: begin
        if (!(cur.kind == mvna_pkg::KIND_TRI && mode) && w == '0) begin
          st       <= mvna_pkg::ST_DEGEN;
          zero_out <= 1'b1;
        end
      end
      mvna_pkg::S_DIVW: begin
        if (alu_done) begin
          v[k] <= v[k][mvna_pkg::NRM_W-1] ? -qn : qn;
          k    <= k_inc;
        end
      end
      mvna_pkg::S_WGTW: begin
        if (alu_done) begin
          wn[k] <= v[k][mvna_pkg::NRM_W-1] ? -alu_res[79:16] : alu_res[79:16];
          k     <= k_inc;
        end
      end
      mvna_pkg::S_ACWR: k <= k_inc;
      mvna_pkg::S_QCHK: begin
        ac[0] <= acc_q.x;
        ac[1] <= acc_q.y;
        ac[2] <= acc_q.z;
        wsum  <= acc_q.w;
        if (acc_q.w == '0) begin
          st       <= mvna_pkg::ST_DEGEN;
          zero_out <= 1'b1;
        end
      end
      mvna_pkg::S_AVGW: begin
        if (alu_done) begin
          k <= k_inc;
          if (ac[k][mvna_pkg::ACC_W-1]) begin
            v[k] <= qover ? {1'b1, {(mvna_pkg::NRM_W - 1){1'b0}}} : -qn;
          end else begin
            v[k] <= qover ? {1'b0, {(mvna_pkg::NRM_W - 1){1'b1}}} : qn;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == mvna_pkg::S_EMIT && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mvna_pkg::S_EMIT && (!result_valid || !result_stall)) begin
      result.normal_x      <= zero_out ? '0 : v[0];
      result.normal_y      <= zero_out ? '0 : v[1];
      result.normal_z      <= zero_out ? '0 : v[2];
      result.result_status <= st;
      result.item_index    <= item_idx;
    end
  end

endmodule

// ===== design/mvna_checker.sv =====
`include "assert_macros.svh"

module mvna_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input mvna_pkg::result_t   result
);

  `MVNA_ASSERT_DIS(a_result_held, clk, rst, result_valid && result_stall |=> result_valid, "result dropped while stalled")
  `MVNA_ASSERT_DIS(a_result_stable, clk, rst, result_valid && result_stall |=> $stable(result), "result changed while stalled")
  `MVNA_ASSERT_DIS(a_bad_zero, clk, rst, result_valid && result.result_status == mvna_pkg::ST_BAD |-> result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0, "bad index with nonzero normal")
  `MVNA_ASSERT_DIS(a_degen_zero, clk, rst, result_valid && result.result_status == mvna_pkg::ST_DEGEN |-> result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0, "degenerate with nonzero normal")
  `MVNA_ASSERT(a_reset_idle, clk, rst |=> !result_valid && !item_stall, "block not idle after reset")

endmodule

bind mesh_vertex_normal_accumulator_top mvna_checker u_mvna_checker (.*);

// ===== dv/tb_mesh_vertex_normal_accumulator_top.sv =====
module tb_mesh_vertex_normal_accumulator_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec3_t;

  localparam logic [63:0] AMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [47:0] WMAX = 48'hFFFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 800;

  class normal_predictor;
    mvna_pkg::pos_t     positions[4096];
    logic signed [63:0] acc_x[4096];
    logic signed [63:0] acc_y[4096];
    logic signed [63:0] acc_z[4096];
    logic [47:0]        weight[4096];
    int unsigned        vcount;
    logic [15:0]        fcount;
    bit                 normalize;
    bit                 smooth;
    mvna_pkg::result_t  pending_normals[$];
    int                 errors;
    int                 checked;
    int                 degen_seen;
    int                 bad_seen;

    function new();
      normalize = 1;
      smooth = 1;
      clear_all();
    endfunction

    function void clear_all();
      for (int i = 0; i < 4096; i++) begin
        positions[i] = '0;
        acc_x[i] = 0;
        acc_y[i] = 0;
        acc_z[i] = 0;
        weight[i] = 0;
      end
      vcount = 0;
      fcount = 0;
    endfunction

    function logic [63:0] mag(logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    function logic signed [63:0] sat48(bit neg, logic [127:0] m);
      logic [127:0] lim;
      logic [63:0] r;
      lim = 128'h8000_0000_0000;
      if (neg) begin
        r = (m >= lim) ? -64'sh8000_0000_0000 : -m[63:0];
      end else begin
        r = (m > lim - 1) ? 64'sh7FFF_FFFF_FFFF : m[63:0];
      end
      return r;
    endfunction

    function logic [63:0] isqrt(logic [127:0] s);
      logic [63:0] r;
      logic [127:0] c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = {64'd0, r | (64'd1 << b)};
        if (c * c <= s) r = c[63:0];
      end
      return r;
    endfunction

    function logic [63:0] length_of(vec3_t v);
      logic [127:0] mx, my, mz;
      mx = mag(v.x);
      my = mag(v.y);
      mz = mag(v.z);
      return isqrt(mx * mx + my * my + mz * mz);
    endfunction

    function logic signed [63:0] scale_unit(logic signed [63:0] c, logic [63:0] len);
      logic [63:0] q;
      q = (mag(c) << 16) / len;
      return c < 0 ? -q : q;
    endfunction

    function bit unitize(inout vec3_t v);
      logic [63:0] len;
      len = length_of(v);
      if (len == 0) return 0;
      v.x = scale_unit(v.x, len);
      v.y = scale_unit(v.y, len);
      v.z = scale_unit(v.z, len);
      return 1;
    endfunction

    function logic signed [63:0] to_q16(logic signed [63:0] raw);
      return sat48(raw < 0, {64'd0, mag(raw)});
    endfunction

    function vec3_t face_normal(int a, int b, int c);
      logic signed [63:0] ux, uy, uz, vx, vy, vz;
      vec3_t n;
      ux = positions[b].x - positions[a].x;
      uy = positions[b].y - positions[a].y;
      uz = positions[b].z - positions[a].z;
      vx = positions[c].x - positions[a].x;
      vy = positions[c].y - positions[a].y;
      vz = positions[c].z - positions[a].z;
      n.x = to_q16(uy * vz - uz * vy);
      n.y = to_q16(uz * vx - ux * vz);
      n.z = to_q16(ux * vy - uy * vx);
      return n;
    endfunction

    function logic signed [63:0] weighted(logic signed [63:0] c, logic [63:0] w);
      logic [127:0] p;
      logic [63:0] m;
      p = {64'd0, mag(c)} * {64'd0, w};
      p = p >> 16;
      m = (p > {64'd0, AMAX}) ? AMAX : p[63:0];
      return c < 0 ? -m : m;
    endfunction

    function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [65:0] s;
      s = a + b;
      if (s > $signed({2'b00, AMAX})) return AMAX;
      if (s < -$signed({2'b00, AMAX})) return -AMAX;
      return s[63:0];
    endfunction

    function logic signed [63:0] average(logic signed [63:0] acc, logic [47:0] w);
      logic [127:0] num;
      num = {64'd0, mag(acc)} << 16;
      return sat48(acc < 0, num / w);
    endfunction

    function void push_result(vec3_t v, mvna_pkg::status_t st, logic [15:0] idx);
      mvna_pkg::result_t r;
      r.normal_x = v.x[47:0];
      r.normal_y = v.y[47:0];
      r.normal_z = v.z[47:0];
      r.result_status = st;
      r.item_index = idx;
      pending_normals = {pending_normals, r};
    endfunction

    function void note_item(mvna_pkg::item_t it);
      int a, b, c;
      int corner[3];
      logic [15:0] face;
      logic [63:0] w, ws;
      vec3_t v, zero;
      a = it.corner_a;
      b = it.corner_b;
      c = it.corner_c;
      zero = '{0, 0, 0};
      case (it.kind)
        mvna_pkg::KIND_LOAD: begin
          if (vcount < 4096) begin
            positions[vcount] = '{it.coord_x, it.coord_y, it.coord_z};
            vcount++;
          end
        end
        mvna_pkg::KIND_CLEAR: clear_all();
        mvna_pkg::KIND_TRI: begin
          face = fcount;
          fcount = fcount + 16'd1;
          if (!smooth) begin
            if (a >= vcount || b >= vcount || c >= vcount) begin
              push_result(zero, mvna_pkg::ST_BAD, face);
            end else begin
              v = face_normal(a, b, c);
              if (length_of(v) == 0) begin
                push_result(zero, mvna_pkg::ST_DEGEN, face);
              end else begin
                if (normalize) void'(unitize(v));
                push_result(v, mvna_pkg::ST_OK, face);
              end
            end
          end else if (a < vcount && b < vcount && c < vcount) begin
            v = face_normal(a, b, c);
            w = length_of(v);
            corner = '{a, b, c};
            foreach (corner[k]) begin
              acc_x[corner[k]] = sat_add(acc_x[corner[k]], weighted(v.x, w));
              acc_y[corner[k]] = sat_add(acc_y[corner[k]], weighted(v.y, w));
              acc_z[corner[k]] = sat_add(acc_z[corner[k]], weighted(v.z, w));
              ws = weight[corner[k]] + w;
              weight[corner[k]] = (ws > {16'd0, WMAX}) ? WMAX : ws[47:0];
            end
          end
        end
        default: begin
          if (a >= vcount) begin
            push_result(zero, mvna_pkg::ST_BAD, 16'(a));
          end else if (weight[a] == 0) begin
            push_result(zero, mvna_pkg::ST_DEGEN, 16'(a));
          end else begin
            v.x = average(acc_x[a], weight[a]);
            v.y = average(acc_y[a], weight[a]);
            v.z = average(acc_z[a], weight[a]);
            if (normalize && !unitize(v)) push_result(zero, mvna_pkg::ST_DEGEN, 16'(a));
            else push_result(v, mvna_pkg::ST_OK, 16'(a));
          end
        end
      endcase
    endfunction

    function void check_result(mvna_pkg::result_t got);
      mvna_pkg::result_t want;
      if (pending_normals.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending_normals.pop_front();
      checked++;
      if (want.result_status == mvna_pkg::ST_DEGEN) degen_seen++;
      if (want.result_status == mvna_pkg::ST_BAD) bad_seen++;
      if (got.normal_x !== want.normal_x) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, want.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== want.normal_y) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, want.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== want.normal_z) begin
        $display("%0t: normal_z expected %0d actual %0d", $time, want.normal_z, got.normal_z);
        errors++;
      end
      if (got.result_status !== want.result_status) begin
        $display("%0t: result_status expected %0d actual %0d", $time,
                 want.result_status, got.result_status);
        errors++;
      end
      if (got.item_index !== want.item_index) begin
        $display("%0t: item_index expected %0d actual %0d", $time,
                 want.item_index, got.item_index);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  mvna_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall = 1'b0;
  mvna_pkg::result_t result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [0:0]        cfg_index;
  logic [0:0]        cfg_data;

  normal_predictor pred = new();
  int send_idle_pct;
  int stall_pct;
  int items_sent;

  mesh_vertex_normal_accumulator_top uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) pred.note_item(item);
      if (result_valid && !result_stall) pred.check_result(result);
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(mvna_pkg::kind_t k, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                      logic [11:0] a, logic [11:0] b, logic [11:0] c);
    int gap;
    gap = 0;
    item_valid <= 1;
    item <= '{k, x, y, z, a, b, c};
    do @(posedge clk); while (item_stall);
    items_sent++;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send(mvna_pkg::KIND_LOAD, x, y, z, 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic triangle(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    send(mvna_pkg::KIND_TRI, 16'($urandom), 16'($urandom), 16'($urandom), a, b, c);
  endtask

  task automatic query(logic [11:0] a);
    send(mvna_pkg::KIND_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), a,
         12'($urandom), 12'($urandom));
  endtask

  task automatic clear_mesh();
    send(mvna_pkg::KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
         12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pred.pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [0:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mvna_pkg::REG_NORMALIZE) pred.normalize = val;
    else pred.smooth = val;
  endtask

  task automatic set_mode(bit norm, bit smooth);
    drain();
    write_reg(mvna_pkg::REG_NORMALIZE, norm);
    write_reg(mvna_pkg::REG_MODE, smooth);
    cfg_valid <= 0;
  endtask

  function automatic logic [11:0] some_vertex();
    return 12'($urandom_range(pred.vcount - 1));
  endfunction

  task automatic random_items(int n);
    int r;
    logic [11:0] a;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (pred.vcount == 0 || (r >= 85 && r < 95)) begin
        load_vertex(rand_coord(), rand_coord(), rand_coord());
      end else if (r < 50) begin
        a = some_vertex();
        if ($urandom_range(9) == 0) triangle(a, a, some_vertex());
        else triangle(a, some_vertex(), some_vertex());
      end else if (r < 75) begin
        query(some_vertex());
      end else if (r < 80) begin
        query(12'($urandom));
      end else if (r < 85) begin
        triangle(12'($urandom), some_vertex(), 12'($urandom));
      end else if (r < 97) begin
        clear_mesh();
      end else begin
        clear_mesh();
      end
    end
  endtask

  initial begin
    rst = 1;
    item_valid = 0;
    item = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extreme coordinates, degenerate and repeated corners, bad indexes.
    load_vertex(16'h8000, 16'h8000, 16'h8000);
    load_vertex(16'h7FFF, 16'h8000, 16'h7FFF);
    load_vertex(16'h8000, 16'h7FFF, 16'h7FFF);
    load_vertex(16'h8000, 16'h8000, 16'h8000);
    load_vertex(16'h0000, 16'h0000, 16'h0000);
    triangle(0, 1, 2);
    triangle(0, 0, 3);
    triangle(2, 1, 0);
    triangle(0, 1, 1);
    triangle(4095, 0, 1);
    query(0);
    query(1);
    query(3);
    query(4);
    query(5);
    query(4095);
    set_mode(1, 0);
    triangle(0, 1, 2);
    triangle(0, 0, 3);
    triangle(0, 4095, 1);
    set_mode(0, 0);
    triangle(2, 0, 1);
    set_mode(0, 1);
    query(0);
    clear_mesh();
    query(0);

    for (int p = 0; p < 8; p++) begin
      set_mode(1'((p >> 1) & 1), 1'((p >> 2) & 1));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      clear_mesh();
      for (int i = $urandom_range(3, 40); i > 0; i--) begin
        load_vertex(rand_coord(), rand_coord(), rand_coord());
      end
      random_items(25);
    end

    drain();
    $display("Sent %0d items over flat and smooth modes, normalized and raw, with idling.",
             items_sent);
    $display("Checked %0d results: %0d degenerate, %0d bad index.",
             pred.checked, pred.degen_seen, pred.bad_seen);
    if (pred.errors == 0 && pred.pending_normals.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mvna_pkg.sv
design/mvna_alu.sv
design/mesh_vertex_normal_accumulator_top.sv
design/mvna_checker.sv
dv/tb_mesh_vertex_normal_accumulator_top.sv
